// ===== rtl/tga_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared constants and types for the run-length packet decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    localparam int PIXEL_COUNT_WIDTH = 24;
    localparam int CNT_W             = PIXEL_COUNT_WIDTH + 1;

    localparam int BYTE_W    = 8;
    localparam int PIXEL_W   = 32;
    localparam int GATHER_W  = 24;
    localparam int REPEAT_W  = 8;
    localparam int BPP_W     = 3;
    localparam int CFG_W     = CNT_W;
    localparam int CFG_IDX_W = 1;
    localparam int M_DATA_W  = PIXEL_W + REPEAT_W;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS    = 1'd1;

    localparam logic [BPP_W-1:0] BPP_RESET    = 3'd3;
    localparam logic [CNT_W-1:0] PIXELS_RESET = CNT_W'(1);

    localparam logic [BYTE_W-1:0] RUN_THRESHOLD = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_OFFSET    = 8'd127;

    typedef struct packed {
        logic [BPP_W-1:0] bytes_per_pixel;
        logic [CNT_W-1:0] image_pixels;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_value;
        logic [REPEAT_W-1:0] repeat_count;
        logic                image_last;
        logic                overrun_flag;
    } pix_result_t;

endpackage

// ===== rtl/tga_rle_packet_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder_unit
// Run-length packet decoder: one stream byte in, one pixel result out per
// finished pixel.
// ----------------------------------------------------------------------------
// Input stream carries the packet bytes (headers and pixel bytes), one per
// transaction. Output stream carries one transaction per finished pixel:
// pixel value and repeat count in tdata, image end in tlast, clamped packet
// in tuser. Header bytes and non-final pixel bytes give no output.
// Path from the final pixel byte to m_tvalid: parser, queue, output register.
// Throughput: one byte per cycle while the queue has space; the parser does
// header decode, byte gather and pixel counting combinationally per byte.
// The user must write registers through cfg_we / cfg_index / cfg_wdata only
// while idle; the block does not enforce it. Reset: parser expects a header,
// pixel count clears, queue and output empty, bytes_per_pixel = 3,
// image_pixels = 1. Receiver stall: output register holds; the two-entry
// queue absorbs results, and s_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tga_rle_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tga_rle_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] stream_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tga_rle_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] pixel_value,
                                                         // [39:32] repeat_count
    output logic                              m_tlast,
    output logic                              m_tuser    // [0] overrun_flag
);
    import tga_rle_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        q_space;
    logic        q_push;
    pix_result_t q_push_data;
    logic        q_valid;
    logic        q_pop;
    pix_result_t q_pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_wdata[BPP_W-1:0];
                REG_IMAGE_PIXELS:    cfg_next.image_pixels    = cfg_wdata[CNT_W-1:0];
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bytes_per_pixel <= BPP_RESET;
            cfg_reg.image_pixels    <= PIXELS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tga_rle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata),
        .res_space  (q_space),
        .res_push   (q_push),
        .res_data   (q_push_data)
    );

    tga_rle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .space     (q_space),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_pop_data)
    );

    tga_rle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (q_valid),
        .res_pop   (q_pop),
        .res_data  (q_pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/tga_rle_front.sv =====
// ----------------------------------------------------------------------------
// tga_rle_front
// Packet parser: classifies header bytes, gathers pixel bytes, counts image
// pixels and issues one result per finished pixel.
// ----------------------------------------------------------------------------
module tga_rle_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tga_rle_pkg::cfg_t              cfg,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  logic [tga_rle_pkg::BYTE_W-1:0] byte_data,
    input  logic                           res_space,
    output logic                           res_push,
    output tga_rle_pkg::pix_result_t       res_data
);
    import tga_rle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RAW,
        PH_RUN
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [REPEAT_W-1:0]  left_reg, left_next;
    logic [1:0]           pos_reg, pos_next;
    logic [GATHER_W-1:0]  gather_reg, gather_next;
    logic [CNT_W-1:0]     done_reg, done_next;

    logic                 take;
    logic [BPP_W-1:0]     bpp_eff;
    logic [BPP_W-1:0]     pos_inc;
    logic [PIXEL_W-1:0]   pixel;
    logic [CNT_W-1:0]     total;
    logic                 done_lt;
    logic [CNT_W-1:0]     remaining;
    logic [CNT_W-1:0]     left_ext;
    logic                 over;
    logic [CNT_W-1:0]     run_len;
    logic [REPEAT_W-1:0]  repeat_cnt;
    logic [CNT_W-1:0]     done_sum;
    logic                 last;

    assign byte_ready = res_space;
    assign take       = byte_valid && res_space;

    always_comb begin
        if (cfg.bytes_per_pixel == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (cfg.bytes_per_pixel > BPP_W'(4)) begin
            bpp_eff = BPP_W'(4);
        end else begin
            bpp_eff = cfg.bytes_per_pixel;
        end
        total     = (cfg.image_pixels == '0) ? CNT_W'(1) : cfg.image_pixels;
        pos_inc   = {1'b0, pos_reg} + BPP_W'(1);
        pixel     = {{(PIXEL_W-GATHER_W){1'b0}}, gather_reg}
                  | (PIXEL_W'(byte_data) << {pos_reg, 3'b000});
        done_lt   = done_reg < total;
        remaining = done_lt ? (total - done_reg) : CNT_W'(1);
        left_ext  = CNT_W'(left_reg);
        over      = !done_lt || (left_ext > remaining);
        run_len   = (left_ext > remaining) ? remaining : left_ext;

        if (phase_reg == PH_RUN) begin
            repeat_cnt = (run_len == '0) ? REPEAT_W'(1) : run_len[REPEAT_W-1:0];
        end else begin
            repeat_cnt = REPEAT_W'(1);
        end
        done_sum = done_reg + CNT_W'(repeat_cnt);
        last     = over || (done_sum >= total);

        phase_next  = phase_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        gather_next = gather_reg;
        done_next   = done_reg;
        res_push    = 1'b0;
        res_data.pixel_value  = pixel;
        res_data.repeat_count = repeat_cnt;
        res_data.image_last   = last;
        res_data.overrun_flag = over;

        if (take) begin
            case (phase_reg)
                PH_RAW, PH_RUN: begin
                    if (pos_inc < bpp_eff) begin
                        gather_next = pixel[GATHER_W-1:0];
                        pos_next    = pos_inc[1:0];
                    end else begin
                        res_push    = 1'b1;
                        pos_next    = '0;
                        gather_next = '0;
                        if (phase_reg == PH_RUN) begin
                            left_next = '0;
                        end else begin
                            left_next = left_reg - REPEAT_W'(1);
                        end
                        done_next = done_sum;
                        if (last) begin
                            done_next = '0;
                            left_next = '0;
                        end
                        if (left_next == '0) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default: begin
                    if (byte_data < RUN_THRESHOLD) begin
                        phase_next = PH_RAW;
                        left_next  = byte_data + REPEAT_W'(1);
                    end else begin
                        phase_next = PH_RUN;
                        left_next  = byte_data - RUN_OFFSET;
                    end
                    pos_next    = '0;
                    gather_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            left_reg   <= '0;
            pos_reg    <= '0;
            gather_reg <= '0;
            done_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
            gather_reg <= gather_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== rtl/tga_rle_queue.sv =====
// ----------------------------------------------------------------------------
// tga_rle_queue
// Two-entry result queue between the packet parser and the output stage.
// ----------------------------------------------------------------------------
module tga_rle_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  tga_rle_pkg::pix_result_t    push_data,
    output logic                        space,
    output logic                        pop_valid,
    input  logic                        pop,
    output tga_rle_pkg::pix_result_t    pop_data
);
    import tga_rle_pkg::*;

    pix_result_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign space     = count_reg != 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tga_rle_back.sv =====
// ----------------------------------------------------------------------------
// tga_rle_back
// Output stage: takes results from the queue and holds them on the result
// stream until the receiver accepts them.
// ----------------------------------------------------------------------------
module tga_rle_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             res_valid,
    output logic                             res_pop,
    input  tga_rle_pkg::pix_result_t         res_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tga_rle_pkg::M_DATA_W-1:0] m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);
    import tga_rle_pkg::*;

    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg;
    logic                last_reg;
    logic                user_reg;
    logic                load;

    assign load    = res_valid && (!valid_reg || m_tready);
    assign res_pop = load;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {res_data.repeat_count, res_data.pixel_value};
            last_reg <= res_data.image_last;
            user_reg <= res_data.overrun_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule
